[src/prmf_pkg.sv]
// Shared types, codes and fixed widths of the push-relabel max-flow block.
`default_nettype none
package prmf_pkg;

	localparam int VC_W      = 5;
	localparam int VID_W     = 4;
	localparam int CAPIN_W   = 16;
	localparam int MF_W      = 20;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINK         = 2'd2;

	localparam logic [VC_W-1:0]  VC_RESET  = 5'd16;
	localparam logic [VID_W-1:0] SRC_RESET = 4'd0;
	localparam logic [VID_W-1:0] SNK_RESET = 4'd15;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_CLR, S_CINIT1, S_CINIT2, S_PRE_RD, S_PRE_WR, S_SWEEP, S_DIS,
		S_PUSH, S_REL_DEC, S_REL_SCAN, S_REL_CMP, S_REL_INC, S_GAP_RD, S_GAP_CHK,
		S_GAP_SCAN, S_GAP_DEC, S_GAP_INC_RD, S_GAP_INC, S_TOT, S_TOT_ACC, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_INIT, CMD_CLR, CMD_CINIT1, CMD_CINIT2, CMD_PRE_RD,
		CMD_PRE_WR, CMD_SWEEP, CMD_DIS, CMD_PUSH, CMD_REL_DEC, CMD_REL_SCAN, CMD_REL_CMP,
		CMD_REL_INC, CMD_GAP_RD, CMD_GAP_CHK, CMD_GAP_SCAN, CMD_GAP_DEC,
		CMD_GAP_INC_RD, CMD_GAP_INC, CMD_TOT, CMD_TOT_ACC
	} cmd_t;

	typedef struct packed {
		logic run_bad;
		logic clr_end;
		logic v_end;
		logic sweep_busy;
		logic eligible;
		logic ex_zero;
		logic arc_end;
		logic u_end;
		logic gap_hit;
		logic lift_hit;
	} status_t;

endpackage
`default_nettype wire

[src/prmf_ctrl.sv]
// Sequencing state machine of the push-relabel max-flow block.
`default_nettype none
module prmf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_entry,
	input  prmf_pkg::status_t status,
	output prmf_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import prmf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (start && last_entry) state_d = S_INIT;
			S_INIT:       state_d = status.run_bad ? S_OUT : S_CLR;
			S_CLR:        state_d = status.clr_end ? S_CINIT1 : S_CLR;
			S_CINIT1:     state_d = S_CINIT2;
			S_CINIT2:     state_d = S_PRE_RD;
			S_PRE_RD:     state_d = status.u_end ? S_SWEEP : S_PRE_WR;
			S_PRE_WR:     state_d = S_PRE_RD;
			S_SWEEP: begin
				if (status.v_end && !status.sweep_busy) state_d = S_TOT;
				else if (status.eligible) state_d = S_DIS;
			end
			S_DIS: begin
				if (status.ex_zero) state_d = S_SWEEP;
				else if (status.arc_end) state_d = S_REL_DEC;
				else state_d = S_PUSH;
			end
			S_PUSH:       state_d = S_DIS;
			S_REL_DEC:    state_d = S_REL_SCAN;
			S_REL_SCAN:   state_d = status.u_end ? S_REL_INC : S_REL_CMP;
			S_REL_CMP:    state_d = S_REL_SCAN;
			S_REL_INC:    state_d = S_GAP_RD;
			S_GAP_RD:     state_d = S_GAP_CHK;
			S_GAP_CHK:    state_d = status.gap_hit ? S_GAP_SCAN : S_DIS;
			S_GAP_SCAN: begin
				if (status.u_end) state_d = S_DIS;
				else if (status.lift_hit) state_d = S_GAP_DEC;
			end
			S_GAP_DEC:    state_d = S_GAP_INC_RD;
			S_GAP_INC_RD: state_d = S_GAP_INC;
			S_GAP_INC:    state_d = S_GAP_SCAN;
			S_TOT:        state_d = status.u_end ? S_OUT : S_TOT_ACC;
			S_TOT_ACC:    state_d = S_TOT;
			S_OUT:        state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = CMD_NONE;
		busy = (state_q != S_IDLE);
		done = (state_q == S_OUT);
		case (state_q)
			S_IDLE:       cmd = start ? CMD_LOAD : CMD_NONE;
			S_INIT:       cmd = CMD_INIT;
			S_CLR:        cmd = CMD_CLR;
			S_CINIT1:     cmd = CMD_CINIT1;
			S_CINIT2:     cmd = CMD_CINIT2;
			S_PRE_RD:     cmd = CMD_PRE_RD;
			S_PRE_WR:     cmd = CMD_PRE_WR;
			S_SWEEP:      cmd = CMD_SWEEP;
			S_DIS:        cmd = CMD_DIS;
			S_PUSH:       cmd = CMD_PUSH;
			S_REL_DEC:    cmd = CMD_REL_DEC;
			S_REL_SCAN:   cmd = CMD_REL_SCAN;
			S_REL_CMP:    cmd = CMD_REL_CMP;
			S_REL_INC:    cmd = CMD_REL_INC;
			S_GAP_RD:     cmd = CMD_GAP_RD;
			S_GAP_CHK:    cmd = CMD_GAP_CHK;
			S_GAP_SCAN:   cmd = CMD_GAP_SCAN;
			S_GAP_DEC:    cmd = CMD_GAP_DEC;
			S_GAP_INC_RD: cmd = CMD_GAP_INC_RD;
			S_GAP_INC:    cmd = CMD_GAP_INC;
			S_TOT:        cmd = CMD_TOT;
			S_TOT_ACC:    cmd = CMD_TOT_ACC;
			default:      cmd = CMD_NONE;
		endcase
	end

endmodule
`default_nettype wire

[src/prmf_datapath.sv]
// Storage and arithmetic of the push-relabel max-flow block.
`default_nettype none
module prmf_datapath #(
	parameter int MAX_VERTICES  = 16,
	parameter int CAPACITY_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [prmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prmf_pkg::CFG_W-1:0]       cfg_data,
	input  prmf_pkg::cmd_t                   cmd,
	input  logic [prmf_pkg::VID_W-1:0]       from_vertex,
	input  logic [prmf_pkg::VID_W-1:0]       to_vertex,
	input  logic [prmf_pkg::CAPIN_W-1:0]     edge_capacity,
	output prmf_pkg::status_t                status,
	output logic [prmf_pkg::MF_W-1:0]        max_flow
);
	import prmf_pkg::*;

	localparam int IW  = $clog2(MAX_VERTICES);
	localparam int VW  = $clog2(MAX_VERTICES + 1);
	localparam int HS  = 2 * MAX_VERTICES + 1;
	localparam int HW  = $clog2(HS);
	localparam int CW  = VW;
	localparam int ENT = MAX_VERTICES * MAX_VERTICES;
	localparam int AW  = $clog2(ENT);
	localparam int FW  = CAPACITY_BITS + 1;
	localparam int RW  = CAPACITY_BITS + 2;
	localparam int EXW = CAPACITY_BITS + IW + 1;

	function automatic logic [AW-1:0] lin(input logic [IW-1:0] x, input logic [IW-1:0] y);
		lin = AW'(x) * AW'(MAX_VERTICES) + AW'(y);
	endfunction

	// Configuration registers.
	logic [VC_W-1:0]  vc_q;
	logic [VID_W-1:0] src_q;
	logic [VID_W-1:0] snk_q;

	// Run registers.
	logic [VW-1:0]         nv_q;
	logic [IW-1:0]         s_q;
	logic [IW-1:0]         t_q;
	logic [VW-1:0]         v_q;
	logic [VW-1:0]         a_q;
	logic [VW-1:0]         u_q;
	logic [AW-1:0]         clr_q;
	logic signed [EXW-1:0] ex_q;
	logic [HW-1:0]         hv_q;
	logic [HW-1:0]         ha_q;
	logic [HW-1:0]         hu_q;
	logic [HW-1:0]         old_q;
	logic [HW-1:0]         best_q;
	logic                  busy_q;
	logic signed [EXW-1:0] total_q;

	logic [HW-1:0]         height_q [MAX_VERTICES];
	logic signed [EXW-1:0] excess_q [MAX_VERTICES];
	logic [VW-1:0]         arc_q    [MAX_VERTICES];

	// Capacities carry valid bits so that reset reads them as zero; flows and
	// level counts are cleared by a pass at the start of every run with a valid source and sink.
	logic [CAPACITY_BITS-1:0] cap_mem  [ENT];
	logic                     cap_vld_q[ENT];
	logic signed [FW-1:0]     flow_mem [ENT];
	logic [CW-1:0]            cnt_mem  [HS];

	logic [CAPACITY_BITS-1:0] cap_rd_q;
	logic                     cap_vld_rd_q;
	logic signed [FW-1:0]     flow_rd_q;
	logic [AW-1:0]            fkey_q;
	logic                     neg_q;
	logic                     self_q;
	logic [CW-1:0]            cnt_rd_q;

	logic [VW-1:0]         nv_c;
	logic                  run_bad_c;
	logic [IW-1:0]         rx;
	logic [IW-1:0]         ry;
	logic [AW-1:0]         caddr;
	logic [AW-1:0]         fkey;
	logic [IW-1:0]         hidx;
	logic [HW-1:0]         h_rd;
	logic [IW-1:0]         eidx;
	logic signed [EXW-1:0] e_rd;
	logic [HW-1:0]         cnt_ra;
	logic [CW-1:0]         cnt_cur;
	logic                  cnt_we;
	logic [HW-1:0]         cnt_wa;
	logic [CW-1:0]         cnt_wd;
	logic                  flow_we;
	logic [AW-1:0]         flow_wa;
	logic signed [FW-1:0]  flow_wd;
	logic [CAPACITY_BITS-1:0] cap_val;
	logic signed [FW-1:0]  f_val;
	logic signed [RW-1:0]  fo;
	logic signed [RW-1:0]  r;
	logic                  r_pos;
	logic signed [EXW-1:0] r_ex;
	logic signed [EXW-1:0] d_ex;
	logic                  push_ok;
	logic signed [RW-1:0]  fnew;
	logic signed [RW-1:0]  fst;
	logic                  load_ok;
	logic [AW-1:0]         load_addr;
	logic [HW-1:0]         nv_h;

	assign nv_h = HW'(nv_q);

	always_comb begin
		if (vc_q < VC_W'(2)) nv_c = VW'(2);
		else if (int'(vc_q) > MAX_VERTICES) nv_c = VW'(MAX_VERTICES);
		else nv_c = VW'(vc_q);
	end

	assign run_bad_c = (src_q == snk_q) || (int'(src_q) >= int'(nv_c))
		|| (int'(snk_q) >= int'(nv_c));

	always_comb begin
		case (cmd)
			CMD_PRE_RD, CMD_TOT: begin
				rx = s_q;
				ry = u_q[IW-1:0];
			end
			CMD_REL_SCAN: begin
				rx = v_q[IW-1:0];
				ry = u_q[IW-1:0];
			end
			default: begin
				rx = v_q[IW-1:0];
				ry = a_q[IW-1:0];
			end
		endcase
	end

	// Flow is antisymmetric, so only the pair with the lower row first is stored.
	assign caddr = lin(rx, ry);
	assign fkey  = (rx < ry) ? lin(rx, ry) : lin(ry, rx);

	always_comb begin
		case (cmd)
			CMD_DIS:                    hidx = a_q[IW-1:0];
			CMD_REL_SCAN, CMD_GAP_SCAN: hidx = u_q[IW-1:0];
			default:                    hidx = v_q[IW-1:0];
		endcase
	end
	assign h_rd = height_q[hidx];

	always_comb begin
		case (cmd)
			CMD_PUSH:   eidx = a_q[IW-1:0];
			CMD_PRE_WR: eidx = u_q[IW-1:0];
			default:    eidx = v_q[IW-1:0];
		endcase
	end
	assign e_rd = excess_q[eidx];

	always_comb begin
		case (cmd)
			CMD_DIS:        cnt_ra = hv_q;
			CMD_REL_SCAN:   cnt_ra = best_q;
			CMD_GAP_SCAN:   cnt_ra = h_rd;
			CMD_GAP_INC_RD: cnt_ra = nv_h;
			default:        cnt_ra = old_q;
		endcase
	end
	assign cnt_cur = cnt_rd_q;

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = old_q;
		cnt_wd = cnt_cur;
		case (cmd)
			CMD_CLR: begin
				cnt_we = (int'(clr_q) < HS);
				cnt_wa = HW'(clr_q);
				cnt_wd = '0;
			end
			CMD_CINIT1: begin
				cnt_we = 1'b1;
				cnt_wa = nv_h;
				cnt_wd = CW'(1);
			end
			CMD_CINIT2: begin
				cnt_we = 1'b1;
				cnt_wa = '0;
				cnt_wd = CW'(nv_q - VW'(1));
			end
			CMD_REL_DEC: begin
				cnt_we = (cnt_cur != '0);
				cnt_wa = old_q;
				cnt_wd = cnt_cur - CW'(1);
			end
			CMD_REL_INC: begin
				cnt_we = 1'b1;
				cnt_wa = best_q;
				cnt_wd = cnt_cur + CW'(1);
			end
			CMD_GAP_DEC: begin
				cnt_we = (cnt_cur != '0);
				cnt_wa = hu_q;
				cnt_wd = cnt_cur - CW'(1);
			end
			CMD_GAP_INC: begin
				cnt_we = 1'b1;
				cnt_wa = nv_h;
				cnt_wd = cnt_cur + CW'(1);
			end
			default: cnt_we = 1'b0;
		endcase
	end

	// Residual capacity of the pair read in the previous cycle.
	assign cap_val = cap_vld_rd_q ? cap_rd_q : '0;
	assign f_val   = flow_rd_q;
	assign fo      = neg_q ? -RW'(f_val) : RW'(f_val);
	assign r       = self_q ? '0 : ($signed(RW'(cap_val)) - fo);
	assign r_pos   = (r > 0);
	assign r_ex    = EXW'(r);
	assign d_ex    = ((cmd == CMD_PUSH) && (ex_q < r_ex)) ? ex_q : r_ex;

	always_comb begin
		case (cmd)
			CMD_PUSH:   push_ok = r_pos && (hv_q == ha_q + HW'(1));
			CMD_PRE_WR: push_ok = r_pos;
			default:    push_ok = 1'b0;
		endcase
	end

	assign fnew = fo + RW'(d_ex);
	assign fst  = neg_q ? -fnew : fnew;

	// The clearing pass shares the single write port of the flow store.
	assign flow_we = push_ok || (cmd == CMD_CLR);
	assign flow_wa = (cmd == CMD_CLR) ? clr_q : fkey_q;
	assign flow_wd = (cmd == CMD_CLR) ? '0 : FW'(fst);

	assign load_ok   = (cmd == CMD_LOAD) && (int'(from_vertex) < MAX_VERTICES)
		&& (int'(to_vertex) < MAX_VERTICES);
	assign load_addr = lin(IW'(from_vertex), IW'(to_vertex));

	assign status.run_bad    = run_bad_c;
	assign status.clr_end    = (clr_q == AW'(ENT - 1));
	assign status.v_end      = (v_q == nv_q);
	assign status.u_end      = (u_q == nv_q);
	assign status.sweep_busy = busy_q;
	assign status.eligible   = (v_q != nv_q) && (v_q[IW-1:0] != s_q)
		&& (v_q[IW-1:0] != t_q) && (e_rd > 0);
	assign status.ex_zero    = !(ex_q > 0);
	assign status.arc_end    = (a_q >= nv_q);
	assign status.gap_hit    = (old_q < nv_h) && (cnt_cur == '0);
	assign status.lift_hit   = (u_q != nv_q) && (h_rd > old_q) && (h_rd < nv_h);

	assign max_flow = total_q[EXW-1] ? '0 : MF_W'($unsigned(total_q));

	// Configuration registers and capacity valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= VC_RESET;
			src_q <= SRC_RESET;
			snk_q <= SNK_RESET;
			for (int i = 0; i < ENT; i++) cap_vld_q[i] <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VERTEX_COUNT: vc_q  <= VC_W'(cfg_data);
					REG_SOURCE:       src_q <= VID_W'(cfg_data);
					REG_SINK:         snk_q <= VID_W'(cfg_data);
					default:          vc_q  <= vc_q;
				endcase
			end
			if (load_ok) cap_vld_q[load_addr] <= 1'b1;
		end
	end

	// Memories: one write and one registered read each per cycle.
	always_ff @(posedge clk) begin
		if (load_ok) cap_mem[load_addr] <= CAPACITY_BITS'(edge_capacity);
		if (flow_we) flow_mem[flow_wa] <= flow_wd;
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cap_rd_q      <= cap_mem[caddr];
		cap_vld_rd_q  <= cap_vld_q[caddr];
		flow_rd_q     <= flow_mem[fkey];
		fkey_q        <= fkey;
		neg_q         <= (rx > ry);
		self_q        <= (rx == ry);
		cnt_rd_q      <= cnt_mem[cnt_ra];
	end

	// Working registers of the run.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_INIT: begin
				nv_q    <= nv_c;
				s_q     <= IW'(src_q);
				t_q     <= IW'(snk_q);
				v_q     <= '0;
				u_q     <= '0;
				clr_q   <= '0;
				busy_q  <= 1'b0;
				total_q <= '0;
				for (int i = 0; i < MAX_VERTICES; i++) begin
					height_q[i] <= '0;
					excess_q[i] <= '0;
					arc_q[i]    <= '0;
				end
			end
			CMD_CLR:    clr_q <= clr_q + AW'(1);
			CMD_CINIT1: height_q[s_q] <= nv_h;
			CMD_CINIT2: u_q <= '0;
			CMD_PRE_WR: begin
				if (push_ok) excess_q[eidx] <= e_rd + d_ex;
				u_q <= u_q + VW'(1);
			end
			CMD_SWEEP: begin
				if (v_q == nv_q) begin
					if (busy_q) begin
						v_q    <= '0;
						busy_q <= 1'b0;
					end else begin
						u_q <= '0;
					end
				end else if (status.eligible) begin
					ex_q   <= e_rd;
					hv_q   <= h_rd;
					a_q    <= arc_q[v_q[IW-1:0]];
					busy_q <= 1'b1;
				end else begin
					v_q <= v_q + VW'(1);
				end
			end
			CMD_DIS: begin
				if (!(ex_q > 0)) begin
					arc_q[v_q[IW-1:0]]    <= a_q;
					excess_q[v_q[IW-1:0]] <= ex_q;
					v_q <= v_q + VW'(1);
				end else if (a_q >= nv_q) begin
					old_q  <= hv_q;
					best_q <= HW'({nv_q, 1'b0});
					u_q    <= '0;
				end else begin
					ha_q <= h_rd;
				end
			end
			CMD_PUSH: begin
				if (push_ok) begin
					excess_q[eidx] <= e_rd + d_ex;
					ex_q <= ex_q - d_ex;
				end
				a_q <= a_q + VW'(1);
			end
			CMD_REL_SCAN: begin
				if (u_q == nv_q) begin
					height_q[v_q[IW-1:0]] <= best_q;
					hv_q <= best_q;
				end else begin
					hu_q <= h_rd;
				end
			end
			CMD_REL_CMP: begin
				if (r_pos && (hu_q + HW'(1) < best_q)) best_q <= hu_q + HW'(1);
				u_q <= u_q + VW'(1);
			end
			CMD_GAP_CHK: begin
				u_q <= '0;
				if (!status.gap_hit) a_q <= '0;
			end
			CMD_GAP_SCAN: begin
				if (u_q == nv_q) a_q <= '0;
				else if (status.lift_hit) hu_q <= h_rd;
				else u_q <= u_q + VW'(1);
			end
			CMD_GAP_DEC: begin
				height_q[u_q[IW-1:0]] <= nv_h;
				if (u_q == v_q) hv_q <= nv_h;
			end
			CMD_GAP_INC: u_q <= u_q + VW'(1);
			CMD_TOT_ACC: begin
				total_q <= total_q + EXW'(fo);
				u_q <= u_q + VW'(1);
			end
			default: total_q <= total_q;
		endcase
	end

endmodule
`default_nettype wire

[src/push_relabel_max_flow_core.sv]
// Top level of the push-relabel maximum flow block.
// Each capacity item is taken when idle; an item without last_entry leaves busy low.
// An item with last_entry runs the flow: start and clearing pass, preflow, then sweeps
// with arc visits, relabels and gap lifts, and last the total of the flow.
// The result shows on max_flow with done for one cycle. Reset zeroes all capacities and
// sets vertex_count, source_vertex, sink_vertex to 16, 0, 15.
`default_nettype none
module push_relabel_max_flow_core #(
	parameter int MAX_VERTICES  = 16,
	parameter int CAPACITY_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prmf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [prmf_pkg::VID_W-1:0]     from_vertex,
	input  logic [prmf_pkg::VID_W-1:0]     to_vertex,
	input  logic [prmf_pkg::CAPIN_W-1:0]   edge_capacity,
	input  logic                           last_entry,
	output logic                           done,
	output logic [prmf_pkg::MF_W-1:0]      max_flow
);
	import prmf_pkg::*;

	// The controller steps through the clearing pass, preflow, sweeps, discharges,
	// relabels, gap lifts and the total; the datapath holds every store and does the arithmetic.
	cmd_t    cmd;
	status_t status;

	prmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_entry (last_entry),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	prmf_datapath #(
		.MAX_VERTICES  (MAX_VERTICES),
		.CAPACITY_BITS (CAPACITY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.from_vertex   (from_vertex),
		.to_vertex     (to_vertex),
		.edge_capacity (edge_capacity),
		.status        (status),
		.max_flow      (max_flow)
	);

endmodule
`default_nettype wire

[src/prmf_checker.sv]
// Port-level checks of the push-relabel max-flow block and their binding.
`default_nettype none
module prmf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic last_entry,
	input logic busy,
	input logic done
);

	// A result only appears while a run holds the block.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	// The final item starts a run.
	a_last_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_entry) |=> busy) else $error("run did not start");

	// Other items are stored without occupying the block.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_entry) |=> !busy) else $error("load held the block");

	// The block frees right after delivering the result.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done)) else $error("block stayed busy after result");

endmodule

bind push_relabel_max_flow_core prmf_checker u_prmf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.last_entry (last_entry),
	.busy       (busy),
	.done       (done)
);
`default_nettype wire

[test/push_relabel_max_flow_core_tb.sv]
// Testbench for the push-relabel max-flow core: directed table, then random runs checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module push_relabel_max_flow_core_tb;
	import prmf_pkg::*;

	localparam int NV_MAX    = 16;
	localparam int SLOTS     = 2 * NV_MAX + 1;
	localparam int SETTLE    = 40;
	localparam int WD_LIMIT  = 400000;
	localparam int RAND_ITEMS = 1030;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [VID_W-1:0]     from_vertex;
	logic [VID_W-1:0]     to_vertex;
	logic [CAPIN_W-1:0]   edge_capacity;
	logic                 last_entry;
	logic                 done;
	logic [MF_W-1:0]      max_flow;

	push_relabel_max_flow_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .from_vertex(from_vertex),
		.to_vertex(to_vertex), .edge_capacity(edge_capacity), .last_entry(last_entry),
		.done(done), .max_flow(max_flow)
	);

	// Predictor state: a private copy of the capacity matrix, the registers and
	// the scratch arrays that one flow computation uses.
	logic [CAPIN_W-1:0] cap_mat [NV_MAX*NV_MAX];
	longint             flow_mat [NV_MAX*NV_MAX];
	int                 height [NV_MAX];
	int                 level_cnt [SLOTS];
	longint             excess [NV_MAX];
	int                 cur_arc [NV_MAX];
	logic [VC_W-1:0]    reg_nv;
	logic [VID_W-1:0]   reg_src;
	logic [VID_W-1:0]   reg_snk;
	int                 n_act;

	logic [MF_W-1:0] flow_expected [$];
	bit              failed;
	bit              idle_on;
	int              quiet_cycles;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t       kind;
		int              a;
		int              b;
		int              c;
		bit              last;
		bit              has_exp;
		logic [MF_W-1:0] exp_flow;
	} stim_row_t;

	function automatic longint residual(int u, int w);
		if (u == w) return 0;
		return longint'(cap_mat[u*NV_MAX+w]) - flow_mat[u*NV_MAX+w];
	endfunction

	function automatic void push_flow(int u, int w, longint d);
		flow_mat[u*NV_MAX+w] += d;
		flow_mat[w*NV_MAX+u] -= d;
		excess[w] += d;
		excess[u] -= d;
	endfunction

	function automatic void level_dec(int h);
		if (h < SLOTS && level_cnt[h] > 0) level_cnt[h]--;
	endfunction

	function automatic void level_inc(int h);
		if (h < SLOTS) level_cnt[h]++;
	endfunction

	function automatic void relabel_vertex(int v);
		int old;
		int best;
		old = height[v];
		best = 2 * n_act;
		level_dec(old);
		for (int u = 0; u < n_act; u++)
			if (residual(v, u) > 0 && height[u] + 1 < best) best = height[u] + 1;
		height[v] = best;
		level_inc(best);
		// Gap heuristic: an emptied level below N lifts everything above it to N.
		if (old < n_act && old < SLOTS && level_cnt[old] == 0) begin
			for (int u = 0; u < n_act; u++) begin
				if (height[u] > old && height[u] < n_act) begin
					level_dec(height[u]);
					height[u] = n_act;
					level_inc(n_act);
				end
			end
		end
	endfunction

	function automatic void discharge_vertex(int v);
		int a;
		longint r;
		while (excess[v] > 0) begin
			a = cur_arc[v];
			if (a >= n_act) begin
				relabel_vertex(v);
				cur_arc[v] = 0;
			end else begin
				r = residual(v, a);
				if (height[v] == height[a] + 1 && r > 0)
					push_flow(v, a, (excess[v] < r) ? excess[v] : r);
				cur_arc[v] = a + 1;
			end
		end
	endfunction

	function automatic logic [MF_W-1:0] compute_max_flow();
		int s;
		int t;
		bit active;
		longint total;
		n_act = int'(reg_nv);
		if (n_act < 2) n_act = 2;
		if (n_act > NV_MAX) n_act = NV_MAX;
		s = int'(reg_src);
		t = int'(reg_snk);
		foreach (flow_mat[i]) flow_mat[i] = 0;
		foreach (level_cnt[i]) level_cnt[i] = 0;
		for (int v = 0; v < NV_MAX; v++) begin
			height[v] = 0;
			excess[v] = 0;
			cur_arc[v] = 0;
		end
		if (s == t || s >= n_act || t >= n_act) return '0;
		height[s] = n_act;
		level_cnt[n_act] = 1;
		level_cnt[0] = n_act - 1;
		for (int v = 0; v < n_act; v++)
			if (residual(s, v) > 0) push_flow(s, v, residual(s, v));
		active = 1;
		while (active) begin
			active = 0;
			for (int v = 0; v < n_act; v++) begin
				if (v != s && v != t && excess[v] > 0) begin
					discharge_vertex(v);
					active = 1;
				end
			end
		end
		total = 0;
		for (int v = 0; v < n_act; v++)
			if (v != s) total += flow_mat[s*NV_MAX+v];
		if (total < 0) total = 0;
		return total[MF_W-1:0];
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results cannot be held off, so every done pulse is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (flow_expected.size() == 0) begin
				$error("max_flow result with nothing expected: actual %0d", max_flow);
				failed = 1;
			end else begin
				if (max_flow !== flow_expected[0]) begin
					$error("max_flow mismatch: expected %0d actual %0d",
						flow_expected[0], max_flow);
					failed = 1;
				end
				void'(flow_expected.pop_front());
			end
		end
	end

	// Watchdog: too long without an item or a result taken ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Offer one item and hold it until the block takes it; the predictor runs when a last item is accepted.
	task automatic send_item(int f, int t, int c, bit last, bit has_exp = 0,
			logic [MF_W-1:0] exp_flow = '0);
		logic [MF_W-1:0] predicted;
		while (idle_on && $urandom_range(99) < 8) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		from_vertex   <= f[VID_W-1:0];
		to_vertex     <= t[VID_W-1:0];
		edge_capacity <= c[CAPIN_W-1:0];
		last_entry    <= last;
		do @(posedge clk); while (busy);
		cap_mat[f*NV_MAX+t] = c[CAPIN_W-1:0];
		if (last) begin
			predicted = compute_max_flow();
			if (has_exp && predicted !== exp_flow) begin
				$error("predictor disagrees on directed row: expected %0d got %0d",
					exp_flow, predicted);
				failed = 1;
			end
			flow_expected.push_back(has_exp ? exp_flow : predicted);
		end
	endtask

	// Registers change only with the block idle: all results in, plus settling time.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		start <= 1'b0;
		@(posedge clk);
		while (flow_expected.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_VERTEX_COUNT: reg_nv  = val[VC_W-1:0];
			REG_SOURCE:       reg_src = val[VID_W-1:0];
			REG_SINK:         reg_snk = val[VID_W-1:0];
			default: ;
		endcase
	endtask

	function automatic int rand_cap();
		case ($urandom_range(7))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(1, 15);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	stim_row_t directed [22] = '{
		// Straight after reset: N = 16, source 0, sink 15, one direct edge.
		'{ROW_ITEM, 0, 15, 65535, 1, 1, 20'd65535},
		'{ROW_ITEM, 0, 1, 65535, 0, 0, 0},
		'{ROW_ITEM, 1, 15, 65535, 1, 1, 20'd131070},
		// A self loop adds nothing.
		'{ROW_ITEM, 3, 3, 1000, 1, 1, 20'd131070},
		'{ROW_ITEM, 15, 15, 0, 1, 1, 20'd131070},
		// Smallest graph: two vertices.
		'{ROW_CFG, REG_VERTEX_COUNT, 2, 0, 0, 0, 0},
		'{ROW_CFG, REG_SINK, 1, 0, 0, 0, 0},
		'{ROW_ITEM, 0, 1, 7, 1, 1, 20'd7},
		// Source equal to sink gives zero.
		'{ROW_CFG, REG_SOURCE, 1, 0, 0, 0, 0},
		'{ROW_ITEM, 1, 0, 9, 1, 1, 20'd0},
		// Vertex count below range clamps to two; a sink beyond N gives zero.
		'{ROW_CFG, REG_VERTEX_COUNT, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SOURCE, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SINK, 3, 0, 0, 0, 0},
		'{ROW_ITEM, 0, 3, 50, 1, 1, 20'd0},
		// Vertex count above range clamps to sixteen; source at the top index.
		'{ROW_CFG, REG_VERTEX_COUNT, 31, 0, 0, 0, 0},
		'{ROW_CFG, REG_SOURCE, 15, 0, 0, 0, 0},
		'{ROW_CFG, REG_SINK, 0, 0, 0, 0, 0},
		'{ROW_ITEM, 15, 0, 65535, 0, 0, 0},
		'{ROW_ITEM, 15, 3, 40000, 0, 0, 0},
		'{ROW_ITEM, 3, 0, 30000, 1, 0, 0},
		'{ROW_CFG, REG_VERTEX_COUNT, 1, 0, 0, 0, 0},
		'{ROW_ITEM, 0, 15, 12, 1, 0, 0}
	};

	initial begin
		int sent;
		int nn;
		int len;
		bit wide;
		failed        = 0;
		idle_on       = 1;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		start         = 1'b0;
		from_vertex   = '0;
		to_vertex     = '0;
		edge_capacity = '0;
		last_entry    = 1'b0;
		foreach (cap_mat[i]) cap_mat[i] = '0;
		reg_nv  = VC_RESET;
		reg_src = SRC_RESET;
		reg_snk = SNK_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].a[CFG_IDX_W-1:0], directed[i].b);
			else
				send_item(directed[i].a, directed[i].b, directed[i].c, directed[i].last,
					directed[i].has_exp, directed[i].exp_flow);
		end

		// Random part: mostly well-formed runs, a batch of entries ending in one marked
		// last, on small graphs; now and then the full sixteen vertices or odd registers.
		sent = 0;
		while (sent < RAND_ITEMS) begin
			idle_on = !(sent > 300 && sent < 500);
			if ($urandom_range(3) == 0) begin
				wide = ($urandom_range(9) == 0);
				nn = wide ? 16 : $urandom_range(2, 6);
				write_reg(REG_VERTEX_COUNT, ($urandom_range(19) == 0) ?
					$urandom_range(0, 31) : nn);
				write_reg(REG_SOURCE, ($urandom_range(9) == 0) ?
					$urandom_range(0, 15) : $urandom_range(0, nn - 1));
				write_reg(REG_SINK, ($urandom_range(9) == 0) ?
					$urandom_range(0, 15) : $urandom_range(0, nn - 1));
			end
			nn = int'(reg_nv);
			if (nn < 2) nn = 2;
			if (nn > NV_MAX) nn = NV_MAX;
			len = $urandom_range(1, (nn > 6) ? 20 : 10);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(9) == 0)
					send_item($urandom_range(0, 15), $urandom_range(0, 15), rand_cap(),
						k == len - 1);
				else
					send_item($urandom_range(0, nn - 1), $urandom_range(0, nn - 1),
						rand_cap(), k == len - 1);
				sent++;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (flow_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (!failed && flow_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
